>>> design/disk_seek_scheduler_assert.svh
// Assertion macros for the disk seek scheduler.
`ifndef DISK_SEEK_SCHEDULER_ASSERT_SVH
`define DISK_SEEK_SCHEDULER_ASSERT_SVH

// Condition a must imply condition b in the same cycle.
`define DSS_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) else $error(msg);

// Condition a must imply condition b in the next cycle.
`define DSS_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error(msg);

`endif

>>> design/dss_pkg.sv
`default_nettype none
package dss_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned SUM_W  = 22;
  localparam logic [SUM_W-1:0] SUM_MAX = 22'd4194303;

  // Register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_SWEEP = 2'd1;
  localparam logic [1:0] REG_START = 2'd2;
  localparam logic [1:0] REG_LASTC = 2'd3;

  // Scheduling modes
  localparam logic [2:0] MODE_FCFS  = 3'd0;
  localparam logic [2:0] MODE_SSTF  = 3'd1;
  localparam logic [2:0] MODE_SCAN  = 3'd2;
  localparam logic [2:0] MODE_CSCAN = 3'd3;
  localparam logic [2:0] MODE_LOOK  = 3'd4;
  localparam logic [2:0] MODE_CLOOK = 3'd5;

  // Visit kinds
  localparam logic [KIND_W-1:0] KIND_SERVE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_JUMP  = 2'd2;

  // Phase actions
  localparam logic [2:0] ACT_SEARCH = 3'd0;
  localparam logic [2:0] ACT_END0   = 3'd1;
  localparam logic [2:0] ACT_ENDL   = 3'd2;
  localparam logic [2:0] ACT_JUMP0  = 3'd3;
  localparam logic [2:0] ACT_DONE   = 3'd4;

  // Search filters
  localparam logic [1:0] FILT_ALL  = 2'd0;
  localparam logic [1:0] FILT_HIGH = 2'd1;
  localparam logic [1:0] FILT_LOW  = 2'd2;

  // Search orders
  localparam logic [1:0] ORD_IDX  = 2'd0;
  localparam logic [1:0] ORD_NEAR = 2'd1;
  localparam logic [1:0] ORD_ASC  = 2'd2;
  localparam logic [1:0] ORD_DESC = 2'd3;

  typedef struct packed {
    logic [2:0] act;
    logic [1:0] filt;
    logic [1:0] ord;
    logic       jump_first;
  } op_t;

  function automatic op_t mk_op(logic [2:0] act, logic [1:0] filt, logic [1:0] ord,
                                logic jf);
    op_t o;
    o.act = act;
    o.filt = filt;
    o.ord = ord;
    o.jump_first = jf;
    return o;
  endfunction

  // Phase list of each mode.
  function automatic op_t plan(logic [2:0] mode, logic sweep_left, logic [2:0] phase);
    op_t done_op;
    op_t lo_desc;
    op_t hi_asc;
    op_t o;
    done_op = mk_op(ACT_DONE, FILT_ALL, ORD_IDX, 1'b0);
    lo_desc = mk_op(ACT_SEARCH, FILT_LOW, ORD_DESC, 1'b0);
    hi_asc  = mk_op(ACT_SEARCH, FILT_HIGH, ORD_ASC, 1'b0);
    o = done_op;
    case (mode)
      MODE_SSTF: begin
        if (phase == 3'd0) o = mk_op(ACT_SEARCH, FILT_ALL, ORD_NEAR, 1'b0);
      end
      MODE_SCAN, MODE_LOOK: begin
        case (phase)
          3'd0: o = sweep_left ? lo_desc : hi_asc;
          3'd1: begin
            if (mode == MODE_LOOK) o = sweep_left ? hi_asc : lo_desc;
            else o = mk_op(sweep_left ? ACT_END0 : ACT_ENDL, FILT_ALL, ORD_IDX, 1'b0);
          end
          3'd2: begin
            if (mode == MODE_SCAN) o = sweep_left ? hi_asc : lo_desc;
          end
          default: o = done_op;
        endcase
      end
      MODE_CSCAN: begin
        case (phase)
          3'd0: o = hi_asc;
          3'd1: o = mk_op(ACT_ENDL, FILT_ALL, ORD_IDX, 1'b0);
          3'd2: o = mk_op(ACT_JUMP0, FILT_ALL, ORD_IDX, 1'b0);
          3'd3: o = mk_op(ACT_SEARCH, FILT_LOW, ORD_ASC, 1'b0);
          default: o = done_op;
        endcase
      end
      MODE_CLOOK: begin
        case (phase)
          3'd0: o = hi_asc;
          3'd1: o = mk_op(ACT_SEARCH, FILT_LOW, ORD_ASC, 1'b1);
          default: o = done_op;
        endcase
      end
      default: begin
        if (phase == 3'd0) o = mk_op(ACT_SEARCH, FILT_ALL, ORD_IDX, 1'b0);
      end
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

>>> design/dss_req_if.sv
`default_nettype none
interface dss_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] request_cylinder;
  logic        last_request;

  modport source (output valid, output request_cylinder, output last_request, input ready);
  modport sink (input valid, input request_cylinder, input last_request, output ready);
endinterface
`default_nettype wire

>>> design/dss_visit_if.sv
`default_nettype none
interface dss_visit_if;
  logic        valid;
  logic        ready;
  logic [15:0] visit_position;
  logic [1:0]  visit_kind;
  logic [21:0] total_movement;
  logic        last_visit;

  modport source (output valid, output visit_position, output visit_kind,
                  output total_movement, output last_visit, input ready);
  modport sink (input valid, input visit_position, input visit_kind,
                input total_movement, input last_visit, output ready);
endinterface
`default_nettype wire

>>> design/dss_cell.sv
`default_nettype none
module dss_cell #(
  parameter int unsigned CW = 16,
  parameter int unsigned IW = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire logic          clear_i,
  input  wire logic          mark_i,
  input  wire logic [IW-1:0] mark_idx_i,
  input  wire logic          valid_i,
  input  wire logic          served_i,
  input  wire logic [IW-1:0] idx_i,
  input  wire logic [CW-1:0] val_i,
  output logic               valid_o,
  output logic               served_o,
  output logic [IW-1:0]      idx_o,
  output logic [CW-1:0]      val_o
);
  logic          valid_q, served_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      served_q <= 1'b0;
    end else if (clear_i) begin
      valid_q  <= 1'b0;
      served_q <= 1'b0;
    end else if (shift_i) begin
      valid_q  <= valid_i;
      served_q <= served_i;
    end else if (mark_i && idx_q == mark_idx_i) begin
      served_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      idx_q <= idx_i;
      val_q <= val_i;
    end
  end

  assign valid_o  = valid_q;
  assign served_o = served_q;
  assign idx_o    = idx_q;
  assign val_o    = val_q;
endmodule
`default_nettype wire

>>> design/dss_pick.sv
`default_nettype none
module dss_pick #(
  parameter int unsigned CW = 16,
  parameter int unsigned IW = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clear_i,
  input  wire logic          en_i,
  input  wire logic [1:0]    filt_i,
  input  wire logic [1:0]    ord_i,
  input  wire logic [CW-1:0] head_i,
  input  wire logic [CW-1:0] start_i,
  input  wire logic          cand_valid_i,
  input  wire logic          cand_served_i,
  input  wire logic [IW-1:0] cand_idx_i,
  input  wire logic [CW-1:0] cand_val_i,
  output logic               found_o,
  output logic [IW-1:0]      best_idx_o,
  output logic [CW-1:0]      best_val_o
);
  import dss_pkg::*;

  logic          found_q;
  logic [IW-1:0] best_idx_q;
  logic [CW-1:0] best_val_q, best_dist_q;
  logic [CW-1:0] cand_dist;
  logic          elig, better;

  assign cand_dist = (cand_val_i >= head_i) ? cand_val_i - head_i : head_i - cand_val_i;

  always_comb begin
    elig = cand_valid_i && !cand_served_i;
    case (filt_i)
      FILT_HIGH: elig = elig && (cand_val_i >= start_i);
      FILT_LOW:  elig = elig && (cand_val_i < start_i);
      default:   elig = elig;
    endcase
    case (ord_i)
      ORD_NEAR: better = (cand_dist < best_dist_q) ||
                         (cand_dist == best_dist_q && cand_idx_i < best_idx_q);
      ORD_ASC:  better = cand_val_i < best_val_q;
      ORD_DESC: better = cand_val_i > best_val_q;
      default:  better = cand_idx_i < best_idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (clear_i) begin
      found_q <= 1'b0;
    end else if (en_i && elig) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && elig && (!found_q || better)) begin
      best_idx_q  <= cand_idx_i;
      best_val_q  <= cand_val_i;
      best_dist_q <= cand_dist;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;
  assign best_val_o = best_val_q;
endmodule
`default_nettype wire

>>> design/disk_seek_scheduler.sv
// Channel  | Dir | Payload
// req      | in  | request_cylinder, last_request
// visit    | out | visit_position, visit_kind, total_movement, last_visit
//
// Requests load one per cycle into a row of cells, ready held high while loading.
// A pass after the last request holds off input; each served request costs one
// full rotation of the cell ring plus the plan, decide and emit states.
// Reset clears the batch and loads register defaults; no clearing pass.
// A stalled visit output holds the pass at its next result.
`default_nettype none
module disk_seek_scheduler #(
  parameter int unsigned MAX_REQUESTS = 32,
  parameter int unsigned CYL_BITS     = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  dss_req_if.sink           req,
  dss_visit_if.source       visit,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i
);
  import dss_pkg::*;
  `include "disk_seek_scheduler_assert.svh"

  localparam int unsigned CW = CYL_BITS;
  localparam int unsigned IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned NW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned AW = ((CW > SUM_W) ? CW : SUM_W) + 1;

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_PLAN   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;

  logic [2:0]  mode_q;
  logic        sweep_q;
  logic [CW-1:0] start_q, lastc_q;

  logic [2:0]  state_q, phase_q;
  logic        first_q;
  logic [IW-1:0] scnt_q;
  logic [NW-1:0] count_q;
  logic [CW-1:0] head_q, res_pos_q;
  logic [SUM_W-1:0] sum_q;
  logic [KIND_W-1:0] res_kind_q;
  logic        res_cnt_q;

  logic        pend_valid_q;
  logic [CW-1:0] pend_pos_q;
  logic [KIND_W-1:0] pend_kind_q;
  logic [SUM_W-1:0] pend_sum_q;

  logic        out_valid_q, out_last_q;
  logic [POS_W-1:0] out_pos_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [SUM_W-1:0] out_sum_q;

  op_t         op;
  logic        in_acc, load_shift, scanning, out_free, commit, push, flush_go;
  logic        mark, found;
  logic [IW-1:0] best_idx;
  logic [CW-1:0] best_val, new_cyl, mdist;
  logic [AW-1:0] sum_ext;
  logic [SUM_W-1:0] sum_d;

  logic          c_valid [MAX_REQUESTS];
  logic          c_served[MAX_REQUESTS];
  logic [IW-1:0] c_idx   [MAX_REQUESTS];
  logic [CW-1:0] c_val   [MAX_REQUESTS];

  assign op         = plan(mode_q, sweep_q, phase_q);
  assign req.ready  = (state_q == S_LOAD);
  assign in_acc     = req.valid && (state_q == S_LOAD);
  assign load_shift = in_acc && (count_q < NW'(MAX_REQUESTS));
  assign scanning   = (state_q == S_SCAN);
  assign out_free   = !out_valid_q || visit.ready;
  assign commit     = (state_q == S_EMIT) && (!pend_valid_q || out_free);
  assign flush_go   = (state_q == S_FLUSH) && out_free;
  assign push       = (commit && pend_valid_q) || (flush_go && pend_valid_q);
  assign mark       = (state_q == S_DECIDE) && found;
  assign new_cyl    = CW'(req.request_cylinder);

  assign mdist   = (res_pos_q >= head_q) ? res_pos_q - head_q : head_q - res_pos_q;
  assign sum_ext = AW'(sum_q) + AW'(mdist);
  always_comb begin
    if (!res_cnt_q) sum_d = sum_q;
    else if (sum_ext > AW'(SUM_MAX)) sum_d = SUM_MAX;
    else sum_d = SUM_W'(sum_ext);
  end

  for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
    logic          v_in, s_in;
    logic [IW-1:0] i_in;
    logic [CW-1:0] x_in;
    if (g == 0) begin : g_head
      // Load pushes a new item in; scan closes the ring.
      assign v_in = scanning ? c_valid[MAX_REQUESTS-1] : 1'b1;
      assign s_in = scanning ? c_served[MAX_REQUESTS-1] : 1'b0;
      assign i_in = scanning ? c_idx[MAX_REQUESTS-1] : IW'(count_q);
      assign x_in = scanning ? c_val[MAX_REQUESTS-1] : new_cyl;
    end else begin : g_body
      assign v_in = c_valid[g-1];
      assign s_in = c_served[g-1];
      assign i_in = c_idx[g-1];
      assign x_in = c_val[g-1];
    end
    dss_cell #(.CW(CW), .IW(IW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (load_shift || scanning),
      .clear_i    (flush_go),
      .mark_i     (mark),
      .mark_idx_i (best_idx),
      .valid_i    (v_in),
      .served_i   (s_in),
      .idx_i      (i_in),
      .val_i      (x_in),
      .valid_o    (c_valid[g]),
      .served_o   (c_served[g]),
      .idx_o      (c_idx[g]),
      .val_o      (c_val[g])
    );
  end

  dss_pick #(.CW(CW), .IW(IW)) u_pick (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       ((state_q == S_PLAN) && (op.act == ACT_SEARCH)),
    .en_i          (scanning),
    .filt_i        (op.filt),
    .ord_i         (op.ord),
    .head_i        (head_q),
    .start_i       (start_q),
    .cand_valid_i  (c_valid[MAX_REQUESTS-1]),
    .cand_served_i (c_served[MAX_REQUESTS-1]),
    .cand_idx_i    (c_idx[MAX_REQUESTS-1]),
    .cand_val_i    (c_val[MAX_REQUESTS-1]),
    .found_o       (found),
    .best_idx_o    (best_idx),
    .best_val_o    (best_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_FCFS;
      sweep_q <= 1'b1;
      start_q <= '0;
      lastc_q <= CW'(199);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:  mode_q  <= cfg_data_i[2:0];
        REG_SWEEP: sweep_q <= cfg_data_i[0];
        REG_START: start_q <= CW'(cfg_data_i);
        REG_LASTC: lastc_q <= CW'(cfg_data_i);
        default:   mode_q  <= mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      phase_q      <= '0;
      first_q      <= 1'b0;
      scnt_q       <= '0;
      count_q      <= '0;
      head_q       <= '0;
      sum_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (push) out_valid_q <= 1'b1;
      else if (visit.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_LOAD: begin
          if (load_shift) count_q <= count_q + NW'(1);
          if (in_acc && req.last_request) begin
            head_q  <= start_q;
            sum_q   <= '0;
            phase_q <= '0;
            first_q <= 1'b1;
            state_q <= S_PLAN;
          end
        end
        S_PLAN: begin
          case (op.act)
            ACT_SEARCH: begin
              scnt_q  <= '0;
              state_q <= S_SCAN;
            end
            ACT_END0, ACT_ENDL, ACT_JUMP0: begin
              phase_q <= phase_q + 3'd1;
              state_q <= S_EMIT;
            end
            default: state_q <= S_FLUSH;
          endcase
        end
        S_SCAN: begin
          scnt_q <= scnt_q + IW'(1);
          if (scnt_q == IW'(MAX_REQUESTS - 1)) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (found) begin
            first_q <= 1'b0;
            state_q <= S_EMIT;
          end else begin
            phase_q <= phase_q + 3'd1;
            first_q <= 1'b1;
            state_q <= S_PLAN;
          end
        end
        S_EMIT: begin
          if (commit) begin
            pend_valid_q <= 1'b1;
            head_q       <= res_pos_q;
            sum_q        <= sum_d;
            state_q      <= S_PLAN;
          end
        end
        S_FLUSH: begin
          if (flush_go) begin
            pend_valid_q <= 1'b0;
            count_q      <= '0;
            state_q      <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // Result being formed for the next commit.
  always_ff @(posedge clk_i) begin
    if (state_q == S_PLAN) begin
      res_cnt_q  <= (op.act != ACT_JUMP0);
      res_kind_q <= (op.act == ACT_JUMP0) ? KIND_JUMP : KIND_END;
      res_pos_q  <= (op.act == ACT_ENDL) ? lastc_q : '0;
    end else if (state_q == S_DECIDE) begin
      res_pos_q  <= best_val;
      res_cnt_q  <= !(op.jump_first && first_q);
      res_kind_q <= (op.jump_first && first_q) ? KIND_JUMP : KIND_SERVE;
    end
    if (commit) begin
      pend_pos_q  <= res_pos_q;
      pend_kind_q <= res_kind_q;
      pend_sum_q  <= sum_d;
    end
    if (push) begin
      out_pos_q  <= POS_W'(pend_pos_q);
      out_kind_q <= pend_kind_q;
      out_sum_q  <= pend_sum_q;
      out_last_q <= flush_go;
    end
  end

  assign visit.valid          = out_valid_q;
  assign visit.visit_position = out_pos_q;
  assign visit.visit_kind     = out_kind_q;
  assign visit.total_movement = out_sum_q;
  assign visit.last_visit     = out_last_q;

  `DSS_ASSERT_IMP(a_load_no_pend, state_q == S_LOAD, !pend_valid_q, "pending result in load")
  `DSS_ASSERT_IMP(a_count_max, 1'b1, count_q <= NW'(MAX_REQUESTS), "request count overflow")
  `DSS_ASSERT_NXT(a_mark_emit, state_q == S_DECIDE && found, state_q == S_EMIT,
                  "selected request not emitted")
endmodule
`default_nettype wire
